### rtl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and codes of the three-wire serial master.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned TICKS_W = 16;

  // command codes on the input channel
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_OPEN  = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RECV  = 3'd3;
  localparam logic [2:0] CMD_CLOSE = 3'd4;

  // running operation, same encoding as the commands that start it
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_OPEN  = 3'd1;
  localparam logic [2:0] OP_SEND  = 3'd2;
  localparam logic [2:0] OP_RECV  = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  // phase within a bit, or phase number of open and close
  localparam logic [1:0] SUB_CLK_LOW  = 2'd0;
  localparam logic [1:0] SUB_DATA     = 2'd1;
  localparam logic [1:0] SUB_CLK_HIGH = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       io_in;
  } item_t;

  typedef struct packed {
    logic ce;
    logic sclk;
    logic io_out;
    logic io_drive;
  } pins_t;

  typedef struct packed {
    pins_t      pins;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rejected;
  } result_t;

endpackage

### rtl/tws_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_in_reg
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module tws_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tws_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output tws_pkg::item_t item
);
  import tws_pkg::*;

  logic  valid_r;
  item_t item_r;

  // held item may only leave when the result stage can take it
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/tws_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_engine
// Command and phase sequencer: pin levels, tick counter and shift register.
// ----------------------------------------------------------------------------
module tws_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  tws_pkg::item_t                    item,
  input  logic [tws_pkg::TICKS_W-1:0]       phase_ticks,
  output tws_pkg::result_t                  result
);
  import tws_pkg::*;

  logic [2:0]         op_r,   op_nxt;
  logic [1:0]         sub_r,  sub_nxt;
  logic [2:0]         bit_r,  bit_nxt;
  logic [TICKS_W-1:0] cnt_r,  cnt_nxt;
  logic [7:0]         sh_r,   sh_nxt;
  pins_t              pins_r, pins_nxt;

  logic [TICKS_W:0]   cnt_inc;
  logic [TICKS_W:0]   limit;
  logic               last_phase;
  logic               rejected;
  logic               rx_valid;
  logic [7:0]         rx_byte;

  // pin change made when a phase begins
  function automatic pins_t start_pins(input logic [2:0] op, input logic [1:0] sub,
                                       input logic [7:0] sh, input pins_t p);
    pins_t q;
    q = p;
    unique case (op)
      OP_OPEN: begin
        if (sub == SUB_CLK_LOW) q.sclk = 1'b0;
        else if (sub == SUB_DATA) q.ce = 1'b0;
        else q.ce = 1'b1;
      end
      OP_CLOSE: begin
        if (sub == SUB_CLK_LOW) q.sclk = 1'b0;
        else q.ce = 1'b0;
      end
      OP_SEND: begin
        if (sub == SUB_CLK_LOW) q.sclk = 1'b0;
        else if (sub == SUB_DATA) q.io_out = sh[0];
        else q.sclk = 1'b1;
      end
      OP_RECV: begin
        if (sub == SUB_CLK_LOW) q.sclk = 1'b0;
        else if (sub == SUB_CLK_HIGH) q.sclk = 1'b1;
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  assign cnt_inc = {1'b0, cnt_r} + {{TICKS_W{1'b0}}, 1'b1};
  assign limit   = {1'b0, (phase_ticks == '0) ? {{(TICKS_W-1){1'b0}}, 1'b1} : phase_ticks};

  always_comb begin
    last_phase = 1'b0;
    unique case (op_r) inside
      OP_OPEN:          last_phase = (sub_r == SUB_CLK_HIGH);
      OP_CLOSE:         last_phase = (sub_r == SUB_DATA);
      OP_SEND, OP_RECV: last_phase = (sub_r == SUB_CLK_HIGH) && (bit_r == LAST_BIT);
      default:          last_phase = 1'b0;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    sub_nxt  = sub_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    pins_nxt = pins_r;
    rejected = 1'b0;
    rx_valid = 1'b0;
    rx_byte  = '0;
    if (item.cmd >= CMD_OPEN && item.cmd <= CMD_CLOSE) begin
      if (op_r != OP_IDLE) begin
        rejected = 1'b1;
      end else begin
        op_nxt  = item.cmd;
        sub_nxt = SUB_CLK_LOW;
        bit_nxt = '0;
        cnt_nxt = '0;
        if (item.cmd == CMD_SEND) begin
          sh_nxt            = item.tx_byte;
          pins_nxt.io_drive = 1'b1;
        end else if (item.cmd == CMD_RECV) begin
          sh_nxt            = '0;
          pins_nxt.io_drive = 1'b0;
        end else if (item.cmd == CMD_OPEN) begin
          pins_nxt.io_drive = 1'b1;
        end
        pins_nxt = start_pins(op_nxt, SUB_CLK_LOW, sh_nxt, pins_nxt);
      end
    end else if (op_r != OP_IDLE) begin
      if (cnt_inc >= limit) begin
        cnt_nxt = '0;
        if (op_r == OP_SEND && sub_r == SUB_CLK_HIGH) begin
          sh_nxt = {1'b0, sh_r[7:1]};
        end
        // receive samples the line at the end of clock low
        if (op_r == OP_RECV && sub_r == SUB_CLK_LOW) begin
          sh_nxt = {item.io_in, sh_r[7:1]};
        end
        if (last_phase) begin
          if (op_r == OP_RECV) begin
            rx_valid = 1'b1;
            rx_byte  = sh_nxt;
          end
          op_nxt  = OP_IDLE;
          sub_nxt = SUB_CLK_LOW;
          bit_nxt = '0;
        end else begin
          if (sub_r == SUB_CLK_HIGH) begin
            sub_nxt = SUB_CLK_LOW;
            bit_nxt = bit_r + 3'd1;
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
          pins_nxt = start_pins(op_r, sub_nxt, sh_nxt, pins_nxt);
        end
      end else begin
        cnt_nxt = cnt_inc[TICKS_W-1:0];
      end
    end
  end

  always_comb begin
    result.pins     = pins_nxt;
    result.busy_res = (op_nxt != OP_IDLE);
    result.rx_valid = rx_valid;
    result.rx_byte  = rx_byte;
    result.rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_IDLE;
      sub_r  <= SUB_CLK_LOW;
      bit_r  <= '0;
      cnt_r  <= '0;
      sh_r   <= '0;
      pins_r <= '0;
    end else if (fire) begin
      op_r   <= op_nxt;
      sub_r  <= sub_nxt;
      bit_r  <= bit_nxt;
      cnt_r  <= cnt_nxt;
      sh_r   <= sh_nxt;
      pins_r <= pins_nxt;
    end
  end

endmodule

### rtl/tws_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tws_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  tws_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output tws_pkg::result_t out_res
);
  import tws_pkg::*;

  logic    valid_r;
  result_t res_r;

  // register can load when empty or when its transfer completes now
  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/three_wire_serial_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_serial_master
// LSB-first three-wire serial master (ce, sclk, data) run by commands and ticks.
// ----------------------------------------------------------------------------
//   channel  handshake          payload
//   in       in_valid/in_stall  in_cmd, in_tx_byte, in_io_in
//   out      out_valid/out_stall out_ce, out_sclk, out_io_out, out_io_drive,
//                               out_busy_res, out_rx_valid, out_rx_byte, out_rejected
//   cfg      cfg_valid/cfg_ready cfg_phase_ticks
//
// One item per cycle while the result side does not stall; its result passes from
// the input register through the sequencer logic into the result register.
// Synchronous active-low reset: idle, all pins low, phase_ticks = 1.
// A stall on the result side holds the result register and with it the input register.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module three_wire_serial_master (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_cmd,
  input  logic [7:0]                   in_tx_byte,
  input  logic                         in_io_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ce,
  output logic                         out_sclk,
  output logic                         out_io_out,
  output logic                         out_io_drive,
  output logic                         out_busy_res,
  output logic                         out_rx_valid,
  output logic [7:0]                   out_rx_byte,
  output logic                         out_rejected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tws_pkg::TICKS_W-1:0]  cfg_phase_ticks
);
  import tws_pkg::*;

  logic [TICKS_W-1:0] phase_ticks_r;
  item_t              in_item;
  item_t              item;
  logic               item_valid;
  logic               advance;
  result_t            res;
  result_t            out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= {{(TICKS_W-1){1'b0}}, 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks_r <= cfg_phase_ticks;
    end
  end

  assign in_item.cmd     = in_cmd;
  assign in_item.tx_byte = in_tx_byte;
  assign in_item.io_in   = in_io_in;

  tws_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tws_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (item_valid && advance),
    .item        (item),
    .phase_ticks (phase_ticks_r),
    .result      (res)
  );

  tws_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_ce       = out_res.pins.ce;
  assign out_sclk     = out_res.pins.sclk;
  assign out_io_out   = out_res.pins.io_out;
  assign out_io_drive = out_res.pins.io_drive;
  assign out_busy_res = out_res.busy_res;
  assign out_rx_valid = out_res.rx_valid;
  assign out_rx_byte  = out_res.rx_byte;
  assign out_rejected = out_res.rejected;

endmodule

### tb/three_wire_serial_master_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_serial_master_check
// Watches the item, result and register channels of the serial master, keeps
// its own model of the pin sequencer and compares every result transfer
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module three_wire_serial_master_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [2:0]                  in_cmd,
  input  logic [7:0]                  in_tx_byte,
  input  logic                        in_io_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_ce,
  input  logic                        out_sclk,
  input  logic                        out_io_out,
  input  logic                        out_io_drive,
  input  logic                        out_busy_res,
  input  logic                        out_rx_valid,
  input  logic [7:0]                  out_rx_byte,
  input  logic                        out_rejected,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tws_pkg::TICKS_W-1:0] cfg_phase_ticks,
  output int                          fail_count,
  output int                          pending,
  output logic                        seq_busy
);
  import tws_pkg::*;

  localparam int unsigned OPEN_PHASES  = 3;
  localparam int unsigned CLOSE_PHASES = 2;
  localparam int unsigned BYTE_PHASES  = 24;
  localparam int          PRINT_CAP    = 100;

  logic [TICKS_W-1:0] ticks_reg;
  logic [2:0]         op;
  int unsigned        phase_idx;
  int unsigned        tick_cnt;
  logic [7:0]         shreg;
  pins_t              pins;
  result_t            due_results[$];
  result_t            want;
  item_t              it;

  initial fail_count = 0;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, exp_val);
    end
    fail_count++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  // pin change made when a phase begins
  function automatic void begin_phase();
    logic [1:0] sub;
    sub = 2'(phase_idx % 3);
    case (op)
      OP_OPEN: begin
        if (phase_idx == 0) pins.sclk = 1'b0;
        else if (phase_idx == 1) pins.ce = 1'b0;
        else pins.ce = 1'b1;
      end
      OP_CLOSE: begin
        if (phase_idx == 0) pins.sclk = 1'b0;
        else pins.ce = 1'b0;
      end
      OP_SEND: begin
        if (sub == SUB_CLK_LOW) pins.sclk = 1'b0;
        else if (sub == SUB_DATA) pins.io_out = shreg[0];
        else pins.sclk = 1'b1;
      end
      OP_RECV: begin
        if (sub == SUB_CLK_LOW) pins.sclk = 1'b0;
        else if (sub == SUB_CLK_HIGH) pins.sclk = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic result_t advance_pins(item_t x);
    result_t     r;
    int unsigned lim;
    int unsigned total;
    logic [1:0]  sub;
    r = '0;
    if (x.cmd >= CMD_OPEN && x.cmd <= CMD_CLOSE) begin
      if (op != OP_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        op = x.cmd;
        phase_idx = 0;
        tick_cnt = 0;
        case (x.cmd)
          CMD_SEND: begin
            shreg = x.tx_byte;
            pins.io_drive = 1'b1;
          end
          CMD_RECV: begin
            shreg = '0;
            pins.io_drive = 1'b0;
          end
          CMD_OPEN: pins.io_drive = 1'b1;
          default: ;
        endcase
        begin_phase();
      end
    end else if (op != OP_IDLE) begin
      // unknown codes count as ticks; a zero register acts as one
      lim = (ticks_reg == 0) ? 1 : 32'(ticks_reg);
      tick_cnt++;
      if (tick_cnt >= lim) begin
        sub = 2'(phase_idx % 3);
        if (op == OP_SEND && sub == SUB_CLK_HIGH) shreg = shreg >> 1;
        if (op == OP_RECV && sub == SUB_CLK_LOW) shreg = {x.io_in, shreg[7:1]};
        tick_cnt = 0;
        phase_idx++;
        total = (op == OP_OPEN) ? OPEN_PHASES :
                (op == OP_CLOSE) ? CLOSE_PHASES : BYTE_PHASES;
        if (phase_idx >= total) begin
          if (op == OP_RECV) begin
            r.rx_valid = 1'b1;
            r.rx_byte = shreg;
          end
          op = OP_IDLE;
          phase_idx = 0;
        end else begin
          begin_phase();
        end
      end
    end
    r.pins = pins;
    r.busy_res = (op != OP_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_reg = 1;
      op = OP_IDLE;
      phase_idx = 0;
      tick_cnt = 0;
      shreg = '0;
      pins = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected", 8'h00, 8'h00);
        end else begin
          want = due_results.pop_front();
          check_field("ce", 8'(out_ce), 8'(want.pins.ce));
          check_field("sclk", 8'(out_sclk), 8'(want.pins.sclk));
          check_field("io_out", 8'(out_io_out), 8'(want.pins.io_out));
          check_field("io_drive", 8'(out_io_drive), 8'(want.pins.io_drive));
          check_field("busy_res", 8'(out_busy_res), 8'(want.busy_res));
          check_field("rx_valid", 8'(out_rx_valid), 8'(want.rx_valid));
          check_field("rx_byte", out_rx_byte, want.rx_byte);
          check_field("rejected", 8'(out_rejected), 8'(want.rejected));
        end
      end
      if (cfg_valid && cfg_ready) begin
        ticks_reg = cfg_phase_ticks;
      end
      if (in_valid && !in_stall) begin
        it = '{cmd: in_cmd, tx_byte: in_tx_byte, io_in: in_io_in};
        due_results.push_back(advance_pins(it));
      end
    end
    pending <= due_results.size();
    seq_busy <= (op != OP_IDLE);
  end

endmodule

### tb/tb_three_wire_serial_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_wire_serial_master
// Drives command and tick items into the serial master: a short directed
// run, then open / byte / close sequences with random data, stray commands
// and cut-short sequences, across several phase lengths including zero and
// the largest. Both channels idle at random; the check module judges results.
// ----------------------------------------------------------------------------
module tb_three_wire_serial_master;
  import tws_pkg::*;

  localparam logic [2:0]  CMD_SPARE    = 3'd5;
  localparam int unsigned OPEN_PHASES  = 3;
  localparam int unsigned CLOSE_PHASES = 2;
  localparam int unsigned BYTE_PHASES  = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [2:0]         in_cmd = CMD_TICK;
  logic [7:0]         in_tx_byte = '0;
  logic               in_io_in = 1'b0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [TICKS_W-1:0] cfg_phase_ticks = '0;

  logic               in_stall;
  logic               out_valid;
  logic               out_ce;
  logic               out_sclk;
  logic               out_io_out;
  logic               out_io_drive;
  logic               out_busy_res;
  logic               out_rx_valid;
  logic [7:0]         out_rx_byte;
  logic               out_rejected;
  logic               cfg_ready;

  int                 fail_count;
  int                 pending;
  logic               seq_busy;
  int                 n_items = 0;
  bit                 calm = 1'b0;
  int unsigned        cur_ticks = 1;

  three_wire_serial_master DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_tx_byte      (in_tx_byte),
    .in_io_in        (in_io_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ce          (out_ce),
    .out_sclk        (out_sclk),
    .out_io_out      (out_io_out),
    .out_io_drive    (out_io_drive),
    .out_busy_res    (out_busy_res),
    .out_rx_valid    (out_rx_valid),
    .out_rx_byte     (out_rx_byte),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_phase_ticks (cfg_phase_ticks)
  );

  three_wire_serial_master_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_tx_byte      (in_tx_byte),
    .in_io_in        (in_io_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ce          (out_ce),
    .out_sclk        (out_sclk),
    .out_io_out      (out_io_out),
    .out_io_drive    (out_io_drive),
    .out_busy_res    (out_busy_res),
    .out_rx_valid    (out_rx_valid),
    .out_rx_byte     (out_rx_byte),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_phase_ticks (cfg_phase_ticks),
    .fail_count      (fail_count),
    .pending         (pending),
    .seq_busy        (seq_busy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  // plain tick most of the time, otherwise one of the unused codes
  function automatic logic [2:0] tick_code();
    if ($urandom_range(0, 3) == 0) return 3'(CMD_SPARE + $urandom_range(0, 2));
    return CMD_TICK;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // present one item and return at the edge of its transfer
  task automatic push_item(logic [2:0] cmd, logic [7:0] tx, logic io);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_tx_byte <= tx;
    in_io_in <= io;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // run ticks until the sequencer has gone idle and every result is in
  task automatic settle();
    drain();
    while (seq_busy) begin
      repeat (cur_ticks) push_item(tick_code(), 8'($urandom), 1'($urandom));
      drain();
    end
  endtask

  task automatic set_ticks(logic [TICKS_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_phase_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_ticks = (v == 0) ? 1 : 32'(v);
  endtask

  // one command with the ticks it needs, now and then a stray command or cut short
  task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx);
    int unsigned n;
    int          mode;
    mode = $urandom_range(0, 3);
    n = ((cmd == CMD_OPEN) ? OPEN_PHASES :
         (cmd == CMD_CLOSE) ? CLOSE_PHASES : BYTE_PHASES) * cur_ticks;
    if ($urandom_range(0, 49) == 0) n = $urandom_range(0, n);
    push_item(cmd, tx, 1'($urandom));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        push_item(3'($urandom_range(CMD_OPEN, CMD_CLOSE)), pick_byte(), 1'($urandom));
      end
      push_item(tick_code(), 8'($urandom),
                (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : 1'($urandom));
    end
  endtask

  task automatic session(int upto);
    while (n_items < upto) begin
      calm = (n_items >= 700 && n_items < 1100);
      run_cmd(CMD_OPEN, pick_byte());
      repeat ($urandom_range(1, 4)) begin
        run_cmd($urandom_range(0, 1) ? CMD_SEND : CMD_RECV, pick_byte());
      end
      run_cmd(CMD_CLOSE, pick_byte());
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) push_item(3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, unused codes, open with a stray command, send with a stray close
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(3'(CMD_SPARE + 2), 8'hFF, 1'b1);
    push_item(CMD_OPEN, 8'h00, 1'b0);
    push_item(CMD_RECV, 8'hFF, 1'b1);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_SPARE, 8'h00, 1'b1);
    push_item(3'(CMD_SPARE + 1), 8'h00, 1'b0);
    push_item(CMD_SEND, 8'hFF, 1'b0);
    repeat (5) push_item(CMD_TICK, 8'h00, 1'b1);
    push_item(CMD_CLOSE, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h00, 1'b0);
    settle();
    push_item(CMD_RECV, 8'h00, 1'b1);
    repeat (BYTE_PHASES) push_item(CMD_TICK, 8'h00, 1'b1);
    push_item(CMD_SEND, 8'h00, 1'b0);
    push_item(CMD_CLOSE, 8'hFF, 1'b0);

    set_ticks(16'h0000);
    session(500);
    set_ticks(16'h0002);
    session(1100);
    set_ticks(16'h0003);
    session(1600);
    set_ticks(16'h0001);
    session(2000);

    // longest phase length: a close that only runs partway, with a stray command
    set_ticks(16'hFFFF);
    push_item(CMD_CLOSE, 8'h00, 1'b0);
    repeat (40) push_item(tick_code(), 8'($urandom), 1'($urandom));
    push_item(CMD_OPEN, 8'h00, 1'b0);
    repeat (10) push_item(tick_code(), 8'($urandom), 1'($urandom));
    drain();

    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### files.f
rtl/tws_pkg.sv
rtl/tws_in_reg.sv
rtl/tws_engine.sv
rtl/tws_out_reg.sv
rtl/three_wire_serial_master.sv
tb/three_wire_serial_master_check.sv
tb/tb_three_wire_serial_master.sv
